// ===== hdl/mer_pkg.sv =====
// ============================================================================
// Midpoint ellipse rasterizer package
// Shared widths, command and phase codes, and the queued job type.
// ============================================================================
package mer_pkg;

    localparam int COORD_BITS  = 12;
    localparam int CTR_W       = COORD_BITS;          // center coordinate
    localparam int RAD_W       = COORD_BITS - 1;      // semi-axis
    localparam int OFF_W       = COORD_BITS;          // running offsets
    localparam int SQ_W        = 2 * RAD_W;           // squared semi-axis
    localparam int MUL_W       = SQ_W + OFF_W;        // shared multiplier product
    localparam int DEC_W       = 3 * RAD_W + 7;       // error and delta terms
    localparam int PIX_W       = COORD_BITS + 2;      // output pixel coordinate

    localparam int QUEUE_DEPTH = 2;                   // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_REGION1 = 2'd1;
    localparam logic [1:0] PH_REGION2 = 2'd2;

    typedef struct packed {
        logic             is_start;
        logic [CTR_W-1:0] center_x;
        logic [CTR_W-1:0] center_y;
        logic [RAD_W-1:0] radius_x;
        logic [RAD_W-1:0] radius_y;
    } mer_job_t;

endpackage

// ===== hdl/mer_if.sv =====
// ============================================================================
// Midpoint ellipse rasterizer channels
// Valid/ready interfaces for the command stream and the pixel stream.
// ============================================================================
interface mer_in_if import mer_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [CTR_W-1:0] center_x;
    logic [CTR_W-1:0] center_y;
    logic [RAD_W-1:0] radius_x;
    logic [RAD_W-1:0] radius_y;

    modport source (output valid, cmd, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink   (input valid, cmd, center_x, center_y, radius_x, radius_y,
                    output ready);
endinterface

interface mer_out_if import mer_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_of_item;
    logic                    ellipse_done;

    modport source (output valid, pixel_x, pixel_y, last_of_item, ellipse_done,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_of_item, ellipse_done,
                    output ready);
endinterface

// ===== hdl/mer_front.sv =====
// ============================================================================
// Midpoint ellipse rasterizer front end
// Accepts command words, tags them as start or advance and queues them.
// ============================================================================
module mer_front import mer_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    mer_in_if.sink   cmds,
    output logic     job_valid,
    input  logic     job_ready,
    output mer_job_t job
);

    mer_job_t            q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;
    mer_job_t            in_job;

    assign cmds.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = cmds.valid && cmds.ready;
    assign job_valid  = (count_reg != '0);
    assign pop        = job_valid && job_ready;
    assign job        = q_mem[rd_ptr_reg];

    always_comb
    begin
        in_job.is_start = (cmds.cmd == CMD_START);
        in_job.center_x = cmds.center_x;
        in_job.center_y = cmds.center_y;
        in_job.radius_x = cmds.radius_x;
        in_job.radius_y = cmds.radius_y;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/mer_engine.sv =====
// ============================================================================
// Midpoint ellipse rasterizer engine
// Runs setup and the region 1 to 2 fold on one shared multiplier, steps the regions and emits pixels.
// ============================================================================
module mer_engine import mer_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  mer_job_t job,
    mer_out_if.source pixels
);

    localparam logic [3:0] S_FETCH = 4'd0;
    localparam logic [3:0] S_SQ_A  = 4'd1;
    localparam logic [3:0] S_SQ_B  = 4'd2;
    localparam logic [3:0] S_PROD  = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_ADJ_B = 4'd6;
    localparam logic [3:0] S_ADJ_A = 4'd7;
    localparam logic [3:0] S_ADJ_F = 4'd8;
    localparam logic [3:0] S_R1A   = 4'd9;
    localparam logic [3:0] S_R1B   = 4'd10;
    localparam logic [3:0] S_R2A   = 4'd11;
    localparam logic [3:0] S_R2B   = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    // control
    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;
    logic       four_reg, four_next;
    logic       ov_reg, ov_next;

    // datapath
    logic [CTR_W-1:0]        cx_reg, cx_next;
    logic [CTR_W-1:0]        cy_reg, cy_next;
    logic [RAD_W-1:0]        a_reg, a_next;
    logic [RAD_W-1:0]        b_reg, b_next;
    logic [SQ_W-1:0]         asq_reg, asq_next;
    logic [SQ_W-1:0]         bsq_reg, bsq_next;
    logic [MUL_W-1:0]        m_reg, m_next;
    logic [OFF_W-1:0]        ox_reg, ox_next;
    logic [OFF_W-1:0]        oy_reg, oy_next;
    logic signed [DEC_W-1:0] dec_reg, dec_next;
    logic signed [DEC_W-1:0] hd_reg, hd_next;
    logic signed [DEC_W-1:0] vd_reg, vd_next;
    logic signed [PIX_W-1:0] px_reg, px_next;
    logic signed [PIX_W-1:0] py_reg, py_next;
    logic                    lst_reg, lst_next;
    logic                    done_reg, done_next;

    logic [SQ_W-1:0]         mul_a;
    logic [OFF_W-1:0]        mul_b;
    logic [MUL_W-1:0]        mul_p;
    logic signed [DEC_W-1:0] asq_s, bsq_s, m_s, asq8, bsq8, vd_dn, hd_up;
    logic [PIX_W-1:0]        cx_w, cy_w, ox_w, oy_w;
    logic                    out_load, emit_last;

    assign mul_p = mul_a * mul_b;

    assign asq_s = signed'(DEC_W'(asq_reg));
    assign bsq_s = signed'(DEC_W'(bsq_reg));
    assign m_s   = signed'(DEC_W'(m_reg));
    assign asq8  = asq_s <<< 3;
    assign bsq8  = bsq_s <<< 3;
    assign vd_dn = vd_reg - asq8;
    assign hd_up = hd_reg + bsq8;

    assign cx_w = PIX_W'(cx_reg);
    assign cy_w = PIX_W'(cy_reg);
    assign ox_w = PIX_W'(ox_reg);
    assign oy_w = PIX_W'(oy_reg);

    assign job_ready = (state_reg == S_FETCH);
    assign out_load  = (state_reg == S_EMIT) && (!ov_reg || pixels.ready);
    assign emit_last = (idx_reg == (four_reg ? 2'd3 : 2'd1));

    assign pixels.valid        = ov_reg;
    assign pixels.pixel_x      = px_reg;
    assign pixels.pixel_y      = py_reg;
    assign pixels.last_of_item = lst_reg;
    assign pixels.ellipse_done = done_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_SQ_A:
            begin
                mul_a = SQ_W'(a_reg);
                mul_b = OFF_W'(a_reg);
            end
            S_SQ_B:
            begin
                mul_a = SQ_W'(b_reg);
                mul_b = OFF_W'(b_reg);
            end
            S_PROD:
            begin
                mul_a = asq_reg;
                mul_b = OFF_W'(b_reg);
            end
            S_ADJ_B:
            begin
                mul_a = bsq_reg;
                mul_b = ox_reg;
            end
            S_ADJ_A:
            begin
                mul_a = asq_reg;
                mul_b = oy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        four_next  = four_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        asq_next   = asq_reg;
        bsq_next   = bsq_reg;
        m_next     = m_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        dec_next   = dec_reg;
        hd_next    = hd_reg;
        vd_next    = vd_reg;

        case (state_reg)
            S_FETCH:
            begin
                idx_next = '0;
                if (job_valid)
                begin
                    if (job.is_start)
                    begin
                        cx_next    = job.center_x;
                        cy_next    = job.center_y;
                        a_next     = job.radius_x;
                        b_next     = job.radius_y;
                        four_next  = 1'b0;
                        state_next = S_SQ_A;
                    end
                    else if (phase_reg == PH_REGION1)
                    begin
                        four_next  = 1'b1;
                        state_next = S_R1A;
                    end
                    else if (phase_reg == PH_REGION2)
                    begin
                        four_next  = 1'b1;
                        state_next = S_R2A;
                    end
                    // advance while idle: drop the word
                end
            end
            S_SQ_A:
            begin
                asq_next   = mul_p[SQ_W-1:0];
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                bsq_next   = mul_p[SQ_W-1:0];
                state_next = S_PROD;
            end
            S_PROD:
            begin
                m_next     = mul_p;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                ox_next    = '0;
                oy_next    = OFF_W'(b_reg);
                hd_next    = '0;
                vd_next    = m_s <<< 3;
                dec_next   = (bsq_s <<< 2) - (m_s <<< 2) + asq_s;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hd_reg < vd_reg)
                begin
                    phase_next = PH_REGION1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ADJ_B;
                end
            end
            S_ADJ_B:
            begin
                m_next     = mul_p;
                state_next = S_ADJ_A;
            end
            S_ADJ_A:
            begin
                dec_next   = dec_reg + bsq_s - (m_s <<< 2) + asq_s;
                m_next     = mul_p;
                state_next = S_ADJ_F;
            end
            S_ADJ_F:
            begin
                dec_next   = dec_reg - (m_s <<< 2);
                phase_next = (oy_reg != '0) ? PH_REGION2 : PH_IDLE;
                state_next = S_EMIT;
            end
            S_R1A:
            begin
                if (!dec_reg[DEC_W-1])
                begin
                    oy_next  = oy_reg - 1'b1;
                    vd_next  = vd_dn;
                    dec_next = dec_reg - vd_dn;
                end
                state_next = S_R1B;
            end
            S_R1B:
            begin
                ox_next    = ox_reg + 1'b1;
                hd_next    = hd_up;
                dec_next   = dec_reg + (bsq_s <<< 2) + hd_up;
                state_next = S_CHECK;
            end
            S_R2A:
            begin
                if (dec_reg[DEC_W-1] || (dec_reg == '0))
                begin
                    ox_next  = ox_reg + 1'b1;
                    hd_next  = hd_up;
                    dec_next = dec_reg + hd_up;
                end
                state_next = S_R2B;
            end
            S_R2B:
            begin
                oy_next    = oy_reg - 1'b1;
                vd_next    = vd_dn;
                dec_next   = dec_reg + (asq_s <<< 2) - vd_dn;
                phase_next = (oy_reg != OFF_W'(1)) ? PH_REGION2 : PH_IDLE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (emit_last)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase
    end

    // output register: pixel order is (+x,+y) (+x,-y) (-x,+y) (-x,-y)
    always_comb
    begin
        ov_next   = ov_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        lst_next  = lst_reg;
        done_next = done_reg;
        if (out_load)
        begin
            ov_next   = 1'b1;
            px_next   = signed'(idx_reg[1] ? cx_w - ox_w : cx_w + ox_w);
            py_next   = signed'(idx_reg[0] ? cy_w - oy_w : cy_w + oy_w);
            lst_next  = emit_last;
            done_next = emit_last && (phase_reg == PH_IDLE);
        end
        else if (pixels.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        asq_reg  <= asq_next;
        bsq_reg  <= bsq_next;
        m_reg    <= m_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        dec_reg  <= dec_next;
        hd_reg   <= hd_next;
        vd_reg   <= vd_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        lst_reg  <= lst_next;
        done_reg <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FETCH;
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            four_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            four_reg  <= four_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !four_reg) |-> !idx_reg[1])
        else $error("pixel index past end of a start word");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && done_reg) |-> lst_reg)
        else $error("ellipse_done without last_of_item");

    a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH && job_valid && job.is_start) |=> (state_reg == S_SQ_A))
        else $error("start word did not enter setup");

    a_region2_rows_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH && phase_reg == PH_REGION2) |-> (oy_reg != '0))
        else $error("region 2 held with no rows left");
`endif

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
// ============================================================================
// Midpoint ellipse rasterizer
// Integer midpoint ellipse: start words set up an ellipse, advance words
// step it and stream out the symmetric pixels.
// ============================================================================
//  channel  dir  handshake    payload
//  cmds     in   valid/ready  cmd, center_x, center_y, radius_x, radius_y
//  pixels   out  valid/ready  pixel_x, pixel_y, last_of_item, ellipse_done
//
//  An advance while idle is dropped. The pace is set by the single shared
//  22x12 multiplier in the engine and the pixel output register, which
//  moves one pixel per cycle while the pixel sink is ready.
//  A two-word queue sits between front end and engine, so commands are
//  accepted while the engine works or the pixel sink stalls.
//  Reset is asynchronous, active low; after it the block is idle at once.
// ============================================================================
module midpoint_ellipse_rasterizer import mer_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mer_in_if.sink    cmds,
    mer_out_if.source pixels
);

    logic     job_valid;
    logic     job_ready;
    mer_job_t job;

    mer_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmds      (cmds),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    mer_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .pixels    (pixels)
    );

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// Midpoint ellipse rasterizer testbench
// Drives start and advance words through the command channel, runs an
// in-bench ellipse stepper on every accepted word and checks each pixel word
// field by field, in order, under several patterns of source and sink idling.
// ============================================================================
module testbench import mer_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 385;
    localparam int STEP_CAP     = 80;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic             cmd;
        logic [CTR_W-1:0] center_x;
        logic [CTR_W-1:0] center_y;
        logic [RAD_W-1:0] radius_x;
        logic [RAD_W-1:0] radius_y;
    } ellipse_cmd_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    last_of_item;
        logic                    ellipse_done;
    } pixel_word_t;

    typedef struct {
        logic cmd;
        int   cx, cy, rx, ry;
        bit   known;
        int   x0, y0, x1, y1;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mer_in_if  cmd_bus ();
    mer_out_if pixel_bus ();

    midpoint_ellipse_rasterizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmds   (cmd_bus),
        .pixels (pixel_bus)
    );

    // Stepper state
    logic [1:0] ell_phase;
    longint     ell_x, ell_y, ell_err, ell_dx, ell_dy;
    longint     ell_asq, ell_bsq, ell_cx, ell_cy;

    pixel_word_t expected_pixels[$];
    int          mismatches;
    int          pixel_count;
    int          busy_items;
    int          send_idle_pct;
    int          recv_stall_pct;

    localparam int DIR_ROWS = 25;
    directed_row_t directed_rows [DIR_ROWS] = '{
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_START,   0,    0,    0,    0,    1, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_START,   4095, 4095, 2047, 2047, 1, 4095, 6142, 4095, 2048},
        '{CMD_ADVANCE, 4095, 4095, 2047, 2047, 0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 4095, 4095, 2047, 2047, 0, 0,    0,    0,    0},
        '{CMD_START,   0,    4095, 2047, 0,    1, 0,    4095, 0,    4095},
        '{CMD_START,   4095, 0,    0,    2047, 1, 4095, 2047, 4095, -2047},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_START,   2048, 2048, 1,    1,    1, 2048, 2049, 2048, 2047},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_START,   100,  200,  3,    2,    1, 100,  202,  100,  198},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_START,   1234, 3000, 2,    5,    1, 1234, 3005, 1234, 2995},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0},
        '{CMD_ADVANCE, 0,    0,    0,    0,    0, 0,    0,    0,    0}
    };

    function automatic void emit_pixel(longint x, longint y);
        pixel_word_t p;
        p.pixel_x      = PIX_W'(x);
        p.pixel_y      = PIX_W'(y);
        p.last_of_item = 1'b0;
        p.ellipse_done = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    function automatic void emit_quad();
        emit_pixel(ell_cx + ell_x, ell_cy + ell_y);
        emit_pixel(ell_cx + ell_x, ell_cy - ell_y);
        emit_pixel(ell_cx - ell_x, ell_cy + ell_y);
        emit_pixel(ell_cx - ell_x, ell_cy - ell_y);
    endfunction

    // Stay in region 1 while the slope is shallow, else fold the error over
    function automatic void settle_region1();
        if (ell_dx < ell_dy)
        begin
            ell_phase = PH_REGION1;
        end
        else
        begin
            ell_err += ell_bsq - 4 * ell_bsq * ell_x + ell_asq - 4 * ell_asq * ell_y;
            ell_phase = (ell_y > 0) ? PH_REGION2 : PH_IDLE;
        end
    endfunction

    function automatic int step_ellipse(ellipse_cmd_t w);
        longint a;
        longint b;
        int     n;
        n = 0;
        if (w.cmd == CMD_START)
        begin
            a = longint'(w.radius_x);
            b = longint'(w.radius_y);
            ell_cx  = longint'(w.center_x);
            ell_cy  = longint'(w.center_y);
            ell_asq = a * a;
            ell_bsq = b * b;
            ell_x   = 0;
            ell_y   = b;
            ell_dx  = 0;
            ell_dy  = 8 * ell_asq * b;
            emit_pixel(ell_cx, ell_cy + b);
            emit_pixel(ell_cx, ell_cy - b);
            n = 2;
            ell_err = 4 * ell_bsq - 4 * ell_asq * b + ell_asq;
            settle_region1();
        end
        else if (ell_phase == PH_REGION1)
        begin
            if (ell_err >= 0)
            begin
                ell_y   -= 1;
                ell_dy  -= 8 * ell_asq;
                ell_err -= ell_dy;
            end
            ell_x   += 1;
            ell_dx  += 8 * ell_bsq;
            ell_err += 4 * ell_bsq + ell_dx;
            emit_quad();
            n = 4;
            settle_region1();
        end
        else if (ell_phase == PH_REGION2)
        begin
            if (ell_err <= 0)
            begin
                ell_x   += 1;
                ell_dx  += 8 * ell_bsq;
                ell_err += ell_dx;
            end
            ell_y   -= 1;
            ell_dy  -= 8 * ell_asq;
            ell_err += 4 * ell_asq - ell_dy;
            emit_quad();
            n = 4;
            ell_phase = (ell_y > 0) ? PH_REGION2 : PH_IDLE;
        end
        if (n > 0)
        begin
            expected_pixels[$].last_of_item = 1'b1;
            if (ell_phase == PH_IDLE)
                expected_pixels[$].ellipse_done = 1'b1;
        end
        return n;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("pixel %0d: %s", pixel_count, msg);
        mismatches++;
    endtask

    // Drive one word, wait for it to be taken, then predict its pixels
    task automatic send_command(ellipse_cmd_t w, output int n);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_bus.valid    <= 1'b1;
        cmd_bus.cmd      <= w.cmd;
        cmd_bus.center_x <= w.center_x;
        cmd_bus.center_y <= w.center_y;
        cmd_bus.radius_x <= w.radius_x;
        cmd_bus.radius_y <= w.radius_y;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        n = step_ellipse(w);
        if (n > 0)
            busy_items++;
    endtask

    // Hold the source until every pixel is out and the engine has settled
    task automatic drain_pixels();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Sink side: random back-pressure
    initial
    begin
        pixel_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            pixel_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                flag_mismatch($sformatf("word (%0d,%0d) with nothing expected",
                                        pixel_bus.pixel_x, pixel_bus.pixel_y));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_bus.pixel_x !== want.pixel_x)
                    flag_mismatch($sformatf("pixel_x %0d, want %0d",
                                            pixel_bus.pixel_x, want.pixel_x));
                if (pixel_bus.pixel_y !== want.pixel_y)
                    flag_mismatch($sformatf("pixel_y %0d, want %0d",
                                            pixel_bus.pixel_y, want.pixel_y));
                if (pixel_bus.last_of_item !== want.last_of_item)
                    flag_mismatch($sformatf("last_of_item %b, want %b",
                                            pixel_bus.last_of_item, want.last_of_item));
                if (pixel_bus.ellipse_done !== want.ellipse_done)
                    flag_mismatch($sformatf("ellipse_done %b, want %b",
                                            pixel_bus.ellipse_done, want.ellipse_done));
            end
            pixel_count++;
        end
    end

    initial
    begin
        ellipse_cmd_t w;
        int           n;
        int           idx;
        int           pick;
        int           steps;
        int           mode;
        int           cur_mode;

        mismatches  = 0;
        pixel_count = 0;
        busy_items  = 0;
        ell_phase   = PH_IDLE;
        ell_x = 0; ell_y = 0; ell_err = 0; ell_dx = 0; ell_dy = 0;
        ell_asq = 0; ell_bsq = 0; ell_cx = 0; ell_cy = 0;
        set_idling(0);

        rst_n            <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.cmd      <= CMD_START;
        cmd_bus.center_x <= '0;
        cmd_bus.center_y <= '0;
        cmd_bus.radius_x <= '0;
        cmd_bus.radius_y <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            w.cmd      = directed_rows[i].cmd;
            w.center_x = CTR_W'(directed_rows[i].cx);
            w.center_y = CTR_W'(directed_rows[i].cy);
            w.radius_x = RAD_W'(directed_rows[i].rx);
            w.radius_y = RAD_W'(directed_rows[i].ry);
            send_command(w, n);
            // Start points are plain: overwrite with the hand-typed coordinates
            if (directed_rows[i].known && n >= 2)
            begin
                idx = expected_pixels.size() - n;
                expected_pixels[idx].pixel_x     = PIX_W'(directed_rows[i].x0);
                expected_pixels[idx].pixel_y     = PIX_W'(directed_rows[i].y0);
                expected_pixels[idx + 1].pixel_x = PIX_W'(directed_rows[i].x1);
                expected_pixels[idx + 1].pixel_y = PIX_W'(directed_rows[i].y1);
            end
        end

        busy_items = 0;
        cur_mode   = 0;
        while (busy_items < RANDOM_ITEMS)
        begin
            mode = (busy_items * 4) / RANDOM_ITEMS;
            if (mode != cur_mode)
            begin
                drain_pixels();
                cur_mode = mode;
                set_idling(mode);
            end
            if ($urandom_range(0, 99) < 80)
            begin
                w.cmd      = CMD_START;
                w.center_x = CTR_W'($urandom);
                w.center_y = CTR_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    w.radius_x = RAD_W'($urandom_range(0, 10));
                    w.radius_y = RAD_W'($urandom_range(0, 10));
                end
                else if (pick < 90)
                begin
                    w.radius_x = RAD_W'($urandom_range(0, 60));
                    w.radius_y = RAD_W'($urandom_range(0, 60));
                end
                else
                begin
                    w.radius_x = RAD_W'($urandom);
                    w.radius_y = RAD_W'($urandom);
                end
                send_command(w, n);
                steps = 0;
                while (ell_phase != PH_IDLE && steps < STEP_CAP)
                begin
                    w          = ellipse_cmd_t'($urandom);
                    w.cmd      = CMD_ADVANCE;
                    send_command(w, n);
                    steps++;
                end
                // a stray advance, which must be ignored once the ellipse has ended
                if ($urandom_range(0, 3) == 0)
                begin
                    w.cmd = CMD_ADVANCE;
                    send_command(w, n);
                end
            end
            else
            begin
                w = ellipse_cmd_t'({$urandom, $urandom});
                send_command(w, n);
            end
        end

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
